// ----- hdl/cpf_pkg.sv -----
// Shared types and constants for the constant propagation folder.
`timescale 1ns / 1ps
package cpf_pkg;
   localparam logic [2:0] OP_ADD    = 3'd0;
   localparam logic [2:0] OP_SUB    = 3'd1;
   localparam logic [2:0] OP_MUL    = 3'd2;
   localparam logic [2:0] OP_DIV    = 3'd3;
   localparam logic [2:0] OP_ASSIGN = 3'd4;

   localparam int REQ_BITS = 80;
   localparam int RSP_BITS = 112;

   // start/result bundle between control and divider
   typedef struct packed {
      logic        start;
      logic [30:0] dividend;
      logic [30:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [30:0] quotient;
   } div_rsp_type;
endpackage

// ----- hdl/cpf_divider.sv -----
// Restoring divider, one quotient bit per cycle, for non-negative 31-bit operands.
`timescale 1ns / 1ps
module cpf_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  cpf_pkg::div_req_type div_req,
   output cpf_pkg::div_rsp_type div_rsp
);
   import cpf_pkg::*;

   logic [30:0] quot_ff, quot_in;
   logic [30:0] rem_ff, rem_in;
   logic [30:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] trial;

   // shift one dividend bit into the partial remainder and try to subtract
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[30]} - {1'b0, dvs_ff};
      if (div_req.start) begin
         quot_in = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = 5'd30;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[31]) begin
            rem_in = trial[30:0];
         end else begin
            rem_in = {rem_ff[29:0], quot_ff[30]};
         end
         quot_in = {quot_ff[29:0], ~trial[31]};
         cnt_in  = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;
endmodule

// ----- hdl/constant_propagation_folder_top.sv -----
// Top level: symbol table memory, fold control and result register.
`timescale 1ns / 1ps
// Constant propagation folder.
// req channel: one quadruple per word; rsp channel: one optimised quadruple
// per word, in order. No configuration port.
// Sequential: one word in flight at a time. Per word: the accept cycle, a
// lookup of each operand in turn in the symbol value memory (one read
// port, registered read), a step to land the second operand, an evaluate
// step and a step to load the output register. The result becomes valid
// in the same cycle in which control returns to idle and can take the next
// word. Add, subtract, multiply, assign and other words take this path; a
// division that runs adds a wait state for the bit-serial divider.
// Valid bits per symbol sit in flip-flops; a word with tlast set clears them
// and the stop flag once it has been evaluated. The value memory is not
// cleared: an entry is used only when its valid bit is set.
// Reset empties the output register and returns control to idle; req_tready
// is high from the first cycle after reset is released.
// If the receiver stalls, the finished word waits in the output register;
// the next word is still accepted and worked on, and its result holds in
// the last step until the output register has been taken.
module constant_propagation_folder_top #(
   parameter int SYMBOL_COUNT = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // lowest up: opcode, src1_is_const, src1_value, src2_is_const,
   // src2_value, dest_symbol, zero fill
   input  logic [cpf_pkg::REQ_BITS-1:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // lowest up: out_opcode, out_src1_is_const, out_src1_value,
   // out_src2_is_const, out_src2_value, out_dest_symbol, folded,
   // folded_value, div_zero_error, zero fill
   output logic [cpf_pkg::RSP_BITS-1:0] rsp_tdata,
   output logic         rsp_tlast
);
   import cpf_pkg::*;

   localparam int IW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD1  = 3'd1;
   localparam logic [2:0] ST_RD2  = 3'd2;
   localparam logic [2:0] ST_EVAL = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;
   localparam logic [2:0] ST_SUB2 = 3'd6;

   logic [31:0] mem [SYMBOL_COUNT];
   logic [31:0] rd_data_ff;
   logic [SYMBOL_COUNT-1:0] valid_ff;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  op_ff;
   logic        c1_ff, c2_ff, end_ff, stop_ff;
   logic [31:0] a_ff, b_ff;
   logic [7:0]  dest_ff;
   logic        hit1_ff, hit2_ff;
   logic        fold_ff;
   logic [31:0] res_ff;
   logic [31:0] prod_ff;

   logic        rsp_valid_ff;
   logic [RSP_BITS-1:0] rsp_data_ff;
   logic        rsp_last_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [30:0] s1v, s2v;
   logic        in1, in2, ind;
   logic        both, do_write;
   logic [IW-1:0] rd_addr, wr_addr, dest_idx;
   logic        wr_en;
   logic        out_fire;

   logic [31:0] add_r, sub_r;
   logic        dec_fold;
   logic [31:0] dec_res;
   logic        dec_err;
   logic        fin_fold;
   logic [31:0] fin_res;

   assign s1v = a_ff[30:0];
   assign s2v = b_ff[30:0];
   assign in1 = {1'b0, a_ff[30:0]} < 32'(SYMBOL_COUNT);
   assign in2 = {1'b0, b_ff[30:0]} < 32'(SYMBOL_COUNT);
   assign ind = {24'd0, dest_ff} < 32'(SYMBOL_COUNT);
   assign dest_idx = IW'(dest_ff);
   assign both = c1_ff && c2_ff && !a_ff[31] && !b_ff[31];

   cpf_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign div_req.start    = (state_ff == ST_EVAL) && !stop_ff && both
                             && op_ff == OP_DIV && b_ff != 32'd0;
   assign div_req.dividend = a_ff[30:0];
   assign div_req.divisor  = b_ff[30:0];

   // memory read address: operand 1 in the first lookup cycle, operand 2 in the second
   assign rd_addr = (state_ff == ST_RD2) ? s2v[IW-1:0] : s1v[IW-1:0];

   // result leaves once the output register is free
   assign out_fire = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   // one write port, used on the first fold of a symbol
   assign do_write = fin_fold && ind && !valid_ff[dest_idx];
   assign wr_en    = out_fire && do_write;
   assign wr_addr  = dest_idx;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= fin_res;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid && req_tready) state_in = ST_RD1;
         ST_RD1:  state_in = ST_RD2;
         ST_RD2:  state_in = ST_SUB2;
         ST_SUB2: state_in = ST_EVAL;
         ST_EVAL: state_in = div_req.start ? ST_DIV : ST_OUT;
         ST_DIV:  if (div_rsp.done) state_in = ST_OUT;
         ST_OUT:  if (out_fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_fire) begin
            rsp_valid_ff <= 1'b1;
            if (end_ff) begin
               valid_ff <= '0;
               stop_ff  <= 1'b0;
            end else begin
               if (do_write) valid_ff[dest_idx] <= 1'b1;
               if (dec_err) stop_ff <= 1'b1;
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            op_ff   <= req_tdata[2:0];
            c1_ff   <= req_tdata[3];
            a_ff    <= {1'b0, req_tdata[34:4]};
            c2_ff   <= req_tdata[35];
            b_ff    <= {1'b0, req_tdata[66:36]};
            dest_ff <= req_tdata[74:67];
            end_ff  <= req_tlast;
         end
         ST_RD1: begin
            hit1_ff <= !c1_ff && in1 && valid_ff[a_ff[IW-1:0]];
            hit2_ff <= !c2_ff && in2 && valid_ff[b_ff[IW-1:0]];
         end
         ST_RD2: begin
            if (hit1_ff) begin
               c1_ff <= 1'b1;
               a_ff  <= rd_data_ff;
            end
         end
         ST_SUB2: begin
            if (hit2_ff) begin
               c2_ff <= 1'b1;
               b_ff  <= rd_data_ff;
            end
         end
         default: ;
      endcase
   end

   // arithmetic on the substituted operands; the product is registered in EVAL
   assign add_r = a_ff + b_ff;
   assign sub_r = a_ff - b_ff;

   always_ff @(posedge clock) begin
      prod_ff <= a_ff * b_ff;
      if (state_ff == ST_DIV && div_rsp.done) begin
         fold_ff <= 1'b1;
         res_ff  <= {1'b0, div_rsp.quotient};
      end else if (state_ff == ST_EVAL) begin
         fold_ff <= 1'b0;
         res_ff  <= '0;
      end
   end

   // fold decision, used in the output step
   always_comb begin
      dec_fold = 1'b0;
      dec_err  = 1'b0;
      dec_res  = '0;
      if (!stop_ff) begin
         if (op_ff == OP_ASSIGN) begin
            if (c1_ff) begin
               dec_fold = 1'b1;
               dec_res  = a_ff;
            end
         end else if (both) begin
            case (op_ff)
               OP_ADD: begin dec_fold = 1'b1; dec_res = add_r; end
               OP_SUB: begin dec_fold = 1'b1; dec_res = sub_r; end
               OP_MUL: begin dec_fold = 1'b1; dec_res = prod_ff; end
               OP_DIV: dec_err = (b_ff == 32'd0);
               default: ;
            endcase
         end
      end
   end

   // division results come from the divider, the rest from the decision
   assign fin_fold = fold_ff || dec_fold;
   assign fin_res  = fold_ff ? res_ff : dec_res;

   // output register
   always_ff @(posedge clock) begin
      if (out_fire) begin
         rsp_data_ff <= {1'b0, dec_err, fin_res, fin_fold,
                         dest_ff, b_ff, c2_ff, a_ff, c1_ff, op_ff};
         rsp_last_ff <= end_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_RD1))
      else $error("accepted word did not start lookup");
   assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (b_ff != 32'd0))
      else $error("divider started with zero divisor");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff)
      else $error("stalled result lost");
endmodule
